### sv/sas_pkg.sv
package sas_pkg;

    localparam int FUNC_W = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W = 7;
    localparam int RATE_W = 36;
    localparam int NOW_W = 64;
    localparam int TICKS_W = 32;

    localparam logic [2:0] FN_CREATE = 3'd0;
    localparam logic [2:0] FN_TICK = 3'd1;
    localparam logic [2:0] FN_FORCE = 3'd2;
    localparam logic [2:0] FN_STEP = 3'd3;
    localparam logic [2:0] FN_RD_FRAME = 3'd4;
    localparam logic [2:0] FN_RD_STATE = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic [1:0] SL_IDLE = 2'd0;
    localparam logic [1:0] SL_RUNNING = 2'd1;
    localparam logic [1:0] SL_COMMITTED = 2'd2;

    localparam logic [15:0] MAX_MS = 16'd60000;
    localparam logic [9:0] MS_PER_S = 10'd1000;
    localparam logic [11:0] TICKS_PER_MS = 12'd2400;

    localparam logic [26:0] RECIP_MS = 27'd68719477;
    localparam int RECIP_SHIFT = 36;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] console;
        logic [3:0] slot_index;
        logic [4:0] sprite;
        logic [15:0] frame_count;
        logic [15:0] duration_ms;
        logic [7:0] interp;
        logic [63:0] now;
    } req_t;

    typedef struct packed {
        logic kind;
        logic [1:0] status;
        logic [6:0] value;
        logic [2:0] out_console;
        logic [4:0] out_sprite;
        logic [3:0] out_slot;
        logic [5:0] out_frame;
        logic last;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic [51:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [31:0] quotient;
    } div_stat_t;

endpackage

### sv/sas_if.sv
interface sas_req_if;
    import sas_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sas_rsp_if;
    import sas_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sas_cfg_if;
    logic valid;
    logic ready;
    logic [35:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/sas_ram.sv
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/sas_div.sv
module sas_div
    import sas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);
    localparam int DIGITS = 4;

    logic [63:0] num_reg, num_next;
    logic [9:0] rem_reg, rem_next;
    logic [25:0] part_reg, part_next;
    logic [15:0] digit_reg, digit_next;
    logic [31:0] quo_reg, quo_next;
    logic [2:0] cnt_reg, cnt_next;
    logic phase_reg, phase_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic [25:0] part;
    logic [52:0] scaled;
    logic [25:0] back;

    assign part = {rem_reg, num_reg[63:48]};
    assign scaled = 53'(part) * 53'(RECIP_MS);
    assign back = 26'(digit_reg) * 26'(MS_PER_S);

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        part_next = part_reg;
        digit_next = digit_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next = 64'(req.dividend);
            rem_next = '0;
            quo_next = '0;
            cnt_next = 3'(DIGITS);
            phase_next = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                part_next = part;
                digit_next = 16'(scaled >> RECIP_SHIFT);
                phase_next = 1'b1;
            end
            else
            begin
                rem_next = 10'(part_reg - back);
                quo_next = {quo_reg[15:0], digit_reg};
                num_next = {num_reg[47:0], 16'd0};
                phase_next = 1'b0;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd1)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            rem_reg <= '0;
            part_reg <= '0;
            digit_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
            phase_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            part_reg <= part_next;
            digit_reg <= digit_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.quotient = quo_reg;
endmodule

### sv/sprite_animation_scheduler.sv
// Sprite animation scheduler: a table of CONSOLES*SLOTS animation slots.
// One request is taken at a time; in_ready stays low until its final reply
// beat (last=1) has been taken. Every slot visit through the shared slot
// memory passes the steps read, evaluate and emit, and can be held by an
// output stall. A create scans the console's slots up to the first idle
// one, then converts milliseconds into timer ticks by reciprocal
// multiplication (one 16-bit quotient digit per estimate and subtract pair;
// the divider is skipped when the rate is 0). A tick visits every slot of
// the table; force tick scans the console's SLOTS slots likewise. Reads and
// steps visit a single slot. After reset the slot table runs one clearing
// pass over all CONSOLES*SLOTS entries before the first request is
// accepted.
module sprite_animation_scheduler
    import sas_pkg::*;
#(
    parameter int CONSOLES = 4,
    parameter int SLOTS = 8,
    parameter int SPRITES = 16,
    parameter int MAX_FRAMES = 64
) (
    input logic clk,
    input logic rst_n,
    sas_cfg_if.sink cfg,
    sas_req_if.sink in_ch,
    sas_rsp_if.source out_ch
);
    localparam int ENTRIES = CONSOLES * SLOTS;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RAM_W = 2 + 7 + 7 + 5 + 32 + 64;

    typedef struct packed {
        logic [1:0] st;
        logic [6:0] cur;
        logic [6:0] tot;
        logic [4:0] spr;
        logic [31:0] ticks;
        logic [63:0] dl;
    } ent_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WAIT, S_EVAL, S_DIV, S_CREATE, S_EMIT, S_REPLY
    } state_t;

    state_t state_reg, state_next;
    logic [35:0] rate_reg, rate_next;
    req_t req_reg, req_next;
    logic [AW:0] addr_reg, addr_next;
    logic [AW:0] end_reg, end_next;
    logic [1:0] status_reg, status_next;
    logic [6:0] value_reg, value_next;
    logic found_reg, found_next;
    logic [AW-1:0] free_reg, free_next;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg, out_next;
    rsp_t pend_reg, pend_next;
    ent_t wr_reg, wr_next;
    logic we_reg, we_next;
    logic [AW-1:0] waddr_reg, waddr_next;
    logic start_reg, start_next;
    logic [2:0] scon_reg, scon_next;
    logic [3:0] sslot_reg, sslot_next;

    ent_t rd_ent;
    logic [RAM_W-1:0] rdata;
    logic [AW-1:0] raddr;
    div_req_t dreq;
    div_stat_t dstat;

    assign raddr = addr_reg[AW-1:0];
    assign rd_ent = ent_t'(rdata);

    sas_ram #(.WIDTH(RAM_W), .DEPTH(ENTRIES)) u_ram (
        .clk  (clk),
        .we   (we_reg),
        .waddr(waddr_reg),
        .wdata(RAM_W'(wr_reg)),
        .raddr(raddr),
        .rdata(rdata)
    );

    sas_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .stat (dstat)
    );

    logic [51:0] product;
    assign product = 52'(req_reg.duration_ms) * 52'(rate_reg);
    assign dreq = {start_reg, product};

    logic [AW:0] con_base;
    assign con_base = (AW+1)'(req_reg.console) * (AW+1)'(SLOTS);

    logic args_ok;
    assign args_ok = (32'(req_reg.console) < CONSOLES) && (req_reg.frame_count != 16'd0)
        && (32'(req_reg.frame_count) <= MAX_FRAMES) && (req_reg.duration_ms != 16'd0)
        && (req_reg.duration_ms <= MAX_MS) && (32'(req_reg.sprite) < SPRITES)
        && (req_reg.interp == 8'd0);
    logic con_ok, slot_ok;
    assign con_ok = 32'(req_reg.console) < CONSOLES;
    assign slot_ok = 32'(req_reg.slot_index) < SLOTS;

    logic [6:0] nxt_cur;
    assign nxt_cur = rd_ent.cur + 7'd1;

    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    logic out_free;
    assign out_free = !out_valid_reg || out_ch.ready;

    logic scan_end;
    assign scan_end = (addr_reg + (AW+1)'(1)) == end_reg;

    always_comb
    begin
        state_next = state_reg;
        rate_next = rate_reg;
        req_next = req_reg;
        addr_next = addr_reg;
        end_next = end_reg;
        status_next = status_reg;
        value_next = value_reg;
        found_next = found_reg;
        free_next = free_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next = out_reg;
        pend_next = pend_reg;
        wr_next = wr_reg;
        we_next = 1'b0;
        waddr_next = waddr_reg;
        start_next = 1'b0;
        scon_next = scon_reg;
        sslot_next = sslot_reg;
        if (cfg.valid)
        begin
            rate_next = cfg.data;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                we_next = 1'b1;
                waddr_next = addr_reg[AW-1:0];
                wr_next = '0;
                if (addr_reg == (AW+1)'(ENTRIES - 1))
                begin
                    addr_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + (AW+1)'(1);
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    req_next = in_ch.data;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                status_next = ST_OK;
                value_next = '0;
                found_next = 1'b0;
                state_next = S_REPLY;
                scon_next = req_reg.console;
                sslot_next = '0;
                unique case (req_reg.func) inside
                    FN_CREATE:
                    begin
                        if (!args_ok)
                        begin
                            status_next = ST_INVALID;
                        end
                        else
                        begin
                            addr_next = con_base;
                            end_next = con_base + (AW+1)'(SLOTS);
                            state_next = S_WAIT;
                        end
                    end
                    FN_TICK:
                    begin
                        addr_next = '0;
                        end_next = (AW+1)'(ENTRIES);
                        scon_next = '0;
                        state_next = S_WAIT;
                    end
                    FN_FORCE:
                    begin
                        if (!con_ok)
                        begin
                            status_next = ST_INVALID;
                        end
                        else
                        begin
                            status_next = ST_NONE;
                            addr_next = con_base;
                            end_next = con_base + (AW+1)'(SLOTS);
                            state_next = S_WAIT;
                        end
                    end
                    FN_STEP, FN_RD_FRAME, FN_RD_STATE:
                    begin
                        if (!con_ok || !slot_ok)
                        begin
                            status_next = ST_INVALID;
                        end
                        else
                        begin
                            addr_next = con_base + (AW+1)'(req_reg.slot_index);
                            end_next = con_base + (AW+1)'(req_reg.slot_index)
                                + (AW+1)'(1);
                            sslot_next = req_reg.slot_index;
                            state_next = S_WAIT;
                        end
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                    end
                endcase
            end
            S_WAIT:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_EMIT;
                unique case (req_reg.func) inside
                    FN_CREATE:
                    begin
                        if (rd_ent.st == SL_IDLE && !found_reg)
                        begin
                            found_next = 1'b1;
                            free_next = addr_reg[AW-1:0];
                            value_next = 7'(sslot_reg);
                        end
                    end
                    FN_TICK, FN_FORCE, FN_STEP:
                    begin
                        if (rd_ent.st == SL_RUNNING && (req_reg.func != FN_TICK
                            || req_reg.now >= rd_ent.dl))
                        begin
                            if (req_reg.func == FN_FORCE)
                            begin
                                status_next = ST_OK;
                            end
                            we_next = 1'b1;
                            waddr_next = addr_reg[AW-1:0];
                            wr_next = rd_ent;
                            wr_next.cur = nxt_cur;
                            if (nxt_cur >= rd_ent.tot)
                            begin
                                wr_next.st = SL_COMMITTED;
                            end
                            else
                            begin
                                wr_next.dl = rd_ent.dl + 64'(rd_ent.ticks);
                                found_next = 1'b1;
                                pend_next = '0;
                                pend_next.out_console = scon_reg;
                                pend_next.out_sprite = rd_ent.spr;
                                pend_next.out_slot = sslot_reg;
                                pend_next.out_frame = nxt_cur[5:0];
                            end
                        end
                        else if (req_reg.func == FN_STEP)
                        begin
                            status_next = ST_INVALID;
                        end
                    end
                    FN_RD_FRAME:
                    begin
                        if (rd_ent.st == SL_RUNNING || rd_ent.st == SL_COMMITTED)
                        begin
                            value_next = rd_ent.cur;
                        end
                        else
                        begin
                            status_next = ST_NONE;
                        end
                    end
                    default:
                    begin
                        value_next = 7'(rd_ent.st);
                    end
                endcase
            end
            S_EMIT:
            begin
                if (req_reg.func == FN_CREATE)
                begin
                    if (found_reg)
                    begin
                        start_next = (rate_reg != '0);
                        state_next = S_DIV;
                    end
                    else if (scan_end)
                    begin
                        status_next = ST_FULL;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        addr_next = addr_reg + (AW+1)'(1);
                        sslot_next = sslot_reg + 4'd1;
                        state_next = S_WAIT;
                    end
                end
                else if (!found_reg || out_free)
                begin
                    if (found_reg)
                    begin
                        out_next = pend_reg;
                        out_valid_next = 1'b1;
                        found_next = 1'b0;
                    end
                    if (scan_end)
                    begin
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        addr_next = addr_reg + (AW+1)'(1);
                        if (sslot_reg == 4'(SLOTS - 1))
                        begin
                            sslot_next = '0;
                            scon_next = scon_reg + 3'd1;
                        end
                        else
                        begin
                            sslot_next = sslot_reg + 4'd1;
                        end
                        state_next = S_WAIT;
                    end
                end
            end
            S_DIV:
            begin
                if (rate_reg == '0 || dstat.done)
                begin
                    state_next = S_CREATE;
                end
            end
            S_CREATE:
            begin
                if (out_free)
                begin
                    we_next = 1'b1;
                    waddr_next = free_reg;
                    wr_next.st = SL_RUNNING;
                    wr_next.cur = '0;
                    wr_next.tot = req_reg.frame_count[6:0];
                    wr_next.spr = req_reg.sprite;
                    if (rate_reg == '0)
                    begin
                        wr_next.ticks = 32'(req_reg.duration_ms) * 32'(TICKS_PER_MS);
                        wr_next.dl = req_reg.now
                            + 64'(32'(req_reg.duration_ms) * 32'(TICKS_PER_MS));
                    end
                    else
                    begin
                        wr_next.ticks = dstat.quotient;
                        wr_next.dl = req_reg.now + 64'(dstat.quotient);
                    end
                    out_next = '0;
                    out_next.out_console = req_reg.console;
                    out_next.out_sprite = req_reg.sprite;
                    out_next.out_slot = value_reg[3:0];
                    out_valid_next = 1'b1;
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_next = '0;
                    out_next.kind = 1'b1;
                    out_next.status = status_reg;
                    out_next.value = value_reg;
                    out_next.last = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            rate_reg <= '0;
            req_reg <= '0;
            addr_reg <= '0;
            end_reg <= '0;
            status_reg <= '0;
            value_reg <= '0;
            found_reg <= 1'b0;
            free_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            pend_reg <= '0;
            wr_reg <= '0;
            we_reg <= 1'b0;
            waddr_reg <= '0;
            start_reg <= 1'b0;
            scon_reg <= '0;
            sslot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rate_reg <= rate_next;
            req_reg <= req_next;
            addr_reg <= addr_next;
            end_reg <= end_next;
            status_reg <= status_next;
            value_reg <= value_next;
            found_reg <= found_next;
            free_reg <= free_next;
            out_valid_reg <= out_valid_next;
            out_reg <= out_next;
            pend_reg <= pend_next;
            wr_reg <= wr_next;
            we_reg <= we_next;
            waddr_reg <= waddr_next;
            start_reg <= start_next;
            scon_reg <= scon_next;
            sslot_reg <= sslot_next;
        end
    end
endmodule

### sv/sas_checker.sv
module sas_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_kind
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == out_kind))
        else $error("last must mark exactly the reply");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");
    a_no_reply_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |-> !in_ready)
        else $error("reply while idle");
endmodule

bind sprite_animation_scheduler sas_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_last (out_ch.data.last),
    .out_kind (out_ch.data.kind)
);
